// ===== sv/prm_pkg.sv =====
// ---------------------------------------------------------------------------
// prm_pkg: shared types and constants of the path root prefix matcher
// Request and status codes, the backslash code and ASCII case folding.
// ---------------------------------------------------------------------------
`default_nettype none

package prm_pkg;

  // Default table dimensions
  localparam int unsigned DEF_MAX_ROOTS      = 16;
  localparam int unsigned DEF_MAX_ROOT_CHARS = 256;

  // Character width of root and path text
  localparam int unsigned CHAR_W = 16;

  // Path separator
  localparam logic [CHAR_W-1:0] BACKSLASH = 16'h005C;

  // Input request kinds
  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_ROOT  = 2'd1,
    REQ_PATH  = 2'd2
  } req_t;

  // Root add status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_LONG = 2'd1,
    ST_QUOTA    = 2'd2
  } add_status_t;

  // Answer kinds
  typedef enum logic {
    ANS_ROOT = 1'b0,
    ANS_PATH = 1'b1
  } answer_kind_t;

  // Map ASCII a-z onto A-Z, leave every other code alone
  function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
    if (c >= 16'h0061 && c <= 16'h007A) begin
      return c - 16'h0020;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/prm_text_ram.sv =====
// ---------------------------------------------------------------------------
// prm_text_ram: root text memory, one row per character position
// Each row holds the character of every root at that position; a write
// updates a single lane, a registered read returns the whole row.
// ---------------------------------------------------------------------------
`default_nettype none

module prm_text_ram
  import prm_pkg::*;
#(
  parameter int unsigned LANES = DEF_MAX_ROOTS,
  parameter int unsigned DEPTH = DEF_MAX_ROOT_CHARS,
  localparam int unsigned AW   = $clog2(DEPTH),
  localparam int unsigned LIW  = (LANES > 1) ? $clog2(LANES) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    we,
  input  wire logic [AW-1:0]           waddr,
  input  wire logic [LIW-1:0]          wlane,
  input  wire logic [CHAR_W-1:0]       wdata,
  input  wire logic [AW-1:0]           raddr,
  output logic      [LANES*CHAR_W-1:0] rdata
);

  logic [LANES*CHAR_W-1:0] mem [DEPTH];

  // Write one lane of a row
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr][wlane*CHAR_W +: CHAR_W] <= wdata;
    end
  end

  // Registered row read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/path_root_prefix_matcher.sv =====
// ---------------------------------------------------------------------------
// path_root_prefix_matcher: case-insensitive root prefix test on paths
// Stores root strings and answers whether a streamed path lies under one.
// ---------------------------------------------------------------------------
// Input stream: one item per character. in_tuser selects clear, root
// character or path character; in_tlast marks the final character.
// Output stream: a root add status when a root ends, a match answer when a
// path ends; other items give no output. The answer sits in the output
// register from the cycle after the last character is taken.
// Throughput is one item per cycle but for the stalls below. The text memory
// holds one row per character position with every root's character in it;
// the row for the next path position is read ahead. A root character written
// into that very row stalls the next item while the row is read again.
// Reset empties the table and needs no sweep of the text memory; after
// reset the first item waits for the first read-ahead row to be registered.
// When the receiver stalls the output register holds its answer and
// in_tready stays low, so no further item is taken until the register is
// free.
// ---------------------------------------------------------------------------
`default_nettype none

module path_root_prefix_matcher
  import prm_pkg::*;
#(
  parameter int unsigned MAX_ROOTS      = DEF_MAX_ROOTS,
  parameter int unsigned MAX_ROOT_CHARS = DEF_MAX_ROOT_CHARS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input items
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] char_code
  input  wire logic [1:0]  in_tuser,   // [1:0] req_type
  input  wire logic        in_tlast,   // last_char
  // result items
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [1:0] add_status, [2] path_matched
  output logic             out_tuser   // answer_kind
);

  localparam int unsigned AW  = $clog2(MAX_ROOT_CHARS);
  localparam int unsigned PW  = $clog2(MAX_ROOT_CHARS + 2);
  localparam int unsigned TW  = $clog2(MAX_ROOTS + 1);
  localparam int unsigned LIW = (MAX_ROOTS > 1) ? $clog2(MAX_ROOTS) : 1;

  // Table and stream state
  logic [PW-1:0]        len_r [MAX_ROOTS];
  logic [PW-1:0]        len_nxt [MAX_ROOTS];
  logic [MAX_ROOTS-1:0] alive_r, alive_nxt;
  logic [TW-1:0]        total_r, total_nxt;
  logic [PW-1:0]        app_pos_r, app_pos_nxt;
  logic                 app_ovf_r, app_ovf_nxt;
  logic [PW-1:0]        path_pos_r, path_pos_nxt;
  logic                 match_r, match_nxt;
  logic                 row_ok_r, row_ok_nxt;

  // Output register
  logic                 out_valid_r, out_valid_nxt;
  answer_kind_t         out_kind_r, out_kind_nxt;
  add_status_t          out_status_r, out_status_nxt;
  logic                 out_match_r, out_match_nxt;

  // Memory ports
  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [AW-1:0]                mem_raddr;
  logic [MAX_ROOTS*CHAR_W-1:0]  mem_row;

  // Per-lane path decisions
  logic [MAX_ROOTS-1:0] lane_hit;
  logic [MAX_ROOTS-1:0] lane_kill;

  logic        accept;
  logic        out_free;
  req_t        req;
  logic [15:0] char_in;

  assign req       = req_t'(in_tuser);
  assign char_in   = in_tdata;
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = out_free && row_ok_r;
  assign accept    = in_tvalid && in_tready;

  prm_text_ram #(
    .LANES (MAX_ROOTS),
    .DEPTH (MAX_ROOT_CHARS)
  ) u_text (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wlane (total_r[LIW-1:0]),
    .wdata (char_in),
    .raddr (mem_raddr),
    .rdata (mem_row)
  );

  // Compare the path character against every root's character at this position
  always_comb begin
    logic [CHAR_W-1:0] rc;
    lane_hit  = '0;
    lane_kill = '0;
    for (int r = 0; r < MAX_ROOTS; r++) begin
      rc = mem_row[r*CHAR_W +: CHAR_W];
      if (TW'(r) < total_r && alive_r[r] && len_r[r] != '0) begin
        if (path_pos_r < len_r[r]) begin
          if (fold_char(rc) != fold_char(char_in)) begin
            lane_kill[r] = 1'b1;
          end else if (path_pos_r == len_r[r] - PW'(1) &&
                       (rc == BACKSLASH || in_tlast)) begin
            lane_hit[r] = 1'b1;
          end
        end else if (path_pos_r == len_r[r]) begin
          lane_hit[r]  = (char_in == BACKSLASH);
          lane_kill[r] = 1'b1;
        end
      end
    end
  end

  // Next state of table, stream positions and output register
  always_comb begin
    for (int r = 0; r < MAX_ROOTS; r++) begin
      len_nxt[r] = len_r[r];
    end
    alive_nxt      = alive_r;
    total_nxt      = total_r;
    app_pos_nxt    = app_pos_r;
    app_ovf_nxt    = app_ovf_r;
    path_pos_nxt   = path_pos_r;
    match_nxt      = match_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_kind_nxt   = out_kind_r;
    out_status_nxt = out_status_r;
    out_match_nxt  = out_match_r;
    mem_we         = 1'b0;
    mem_waddr      = app_pos_r[AW-1:0];

    if (accept) begin
      unique case (req)
        REQ_CLEAR: begin
          for (int r = 0; r < MAX_ROOTS; r++) begin
            len_nxt[r] = '0;
          end
          total_nxt    = '0;
          app_pos_nxt  = '0;
          app_ovf_nxt  = 1'b0;
          path_pos_nxt = '0;
          match_nxt    = 1'b0;
          alive_nxt    = '1;
        end
        REQ_ROOT: begin
          // Store the character or flag the root as too long
          if (app_pos_r >= PW'(MAX_ROOT_CHARS)) begin
            app_ovf_nxt = 1'b1;
          end else begin
            mem_we      = (total_r < TW'(MAX_ROOTS));
            app_pos_nxt = app_pos_r + PW'(1);
          end
          if (in_tlast) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = ANS_ROOT;
            out_match_nxt = 1'b0;
            if (app_ovf_nxt) begin
              out_status_nxt = ST_TOO_LONG;
            end else if (total_r >= TW'(MAX_ROOTS)) begin
              out_status_nxt = ST_QUOTA;
            end else begin
              out_status_nxt                = ST_OK;
              len_nxt[total_r[LIW-1:0]]     = app_pos_nxt;
              alive_nxt[total_r[LIW-1:0]]   = (path_pos_r == '0);
              total_nxt                     = total_r + TW'(1);
            end
            app_pos_nxt = '0;
            app_ovf_nxt = 1'b0;
          end
        end
        REQ_PATH: begin
          alive_nxt = alive_r & ~lane_kill;
          match_nxt = match_r || (lane_hit != '0);
          if (path_pos_r <= PW'(MAX_ROOT_CHARS)) begin
            path_pos_nxt = path_pos_r + PW'(1);
          end
          if (in_tlast) begin
            out_valid_nxt  = 1'b1;
            out_kind_nxt   = ANS_PATH;
            out_status_nxt = ST_OK;
            out_match_nxt  = match_nxt;
            path_pos_nxt   = '0;
            match_nxt      = 1'b0;
            alive_nxt      = '1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Read ahead the row of the next path position; a write into it spoils the read
  always_comb begin
    mem_raddr = (path_pos_nxt < PW'(MAX_ROOT_CHARS)) ? path_pos_nxt[AW-1:0] : '0;
    row_ok_nxt = !(mem_we && mem_waddr == mem_raddr);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < MAX_ROOTS; r++) begin
        len_r[r] <= '0;
      end
      alive_r     <= '1;
      total_r     <= '0;
      app_pos_r   <= '0;
      app_ovf_r   <= 1'b0;
      path_pos_r  <= '0;
      match_r     <= 1'b0;
      row_ok_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      for (int r = 0; r < MAX_ROOTS; r++) begin
        len_r[r] <= len_nxt[r];
      end
      alive_r     <= alive_nxt;
      total_r     <= total_nxt;
      app_pos_r   <= app_pos_nxt;
      app_ovf_r   <= app_ovf_nxt;
      path_pos_r  <= path_pos_nxt;
      match_r     <= match_nxt;
      row_ok_r    <= row_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    out_kind_r   <= out_kind_nxt;
    out_status_r <= out_status_nxt;
    out_match_r  <= out_match_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {5'b0, out_match_r, out_status_r};

  // Checks
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= TW'(MAX_ROOTS))
    else $error("root count beyond table size");

  a_ovf_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    app_ovf_r |-> app_pos_r == PW'(MAX_ROOT_CHARS))
    else $error("overflow flag without a full root");

  a_answer_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_tlast && (req == REQ_ROOT || req == REQ_PATH) |=> out_valid_r)
    else $error("final character gave no answer");

  a_root_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == ANS_ROOT |-> !out_match_r)
    else $error("root status carries a match flag");

endmodule

`default_nettype wire

// ===== dv/tb_path_root_prefix_matcher.sv =====
// ---------------------------------------------------------------------------
// tb_path_root_prefix_matcher: self-checking bench for the root prefix matcher
// Streams root and path characters through the block, predicts each root add
// status and path match answer in the bench, and compares every result item.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_path_root_prefix_matcher;
  import prm_pkg::*;

  localparam int unsigned ROOTS      = DEF_MAX_ROOTS;
  localparam int unsigned ROOT_CHARS = DEF_MAX_ROOT_CHARS;
  localparam logic [1:0]  REQ_UNUSED = 2'd3;
  localparam int          DRAIN_CYCLES = 20;

  typedef struct {
    answer_kind_t kind;
    add_status_t  status;
    logic         matched;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [15:0] char_code
  logic [1:0]  in_tuser;   // [1:0] req_type
  logic        in_tlast;   // last_char
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [1:0] add_status, [2] path_matched
  logic        out_tuser;  // answer_kind

  // Bench copy of the block state
  logic [15:0] root_chars [ROOTS][ROOT_CHARS];
  int unsigned root_len [ROOTS];
  int unsigned root_cnt;
  int unsigned build_pos;
  logic        build_ovf;
  int unsigned walk_pos;
  logic        live [ROOTS];
  logic        hit;

  answer_t pending_answers [$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int stall_left  = 0;
  int items_sent  = 0;
  int errors      = 0;
  int roots_stored = 0, roots_too_long = 0, roots_over_quota = 0;
  int paths_matched = 0, paths_missed = 0;

  path_root_prefix_matcher #(
    .MAX_ROOTS      (ROOTS),
    .MAX_ROOT_CHARS (ROOT_CHARS)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #6 clk = ~clk;

  // ASCII a-z onto A-Z, everything else unchanged
  function automatic logic [15:0] upcase(input logic [15:0] c);
    if (c >= 16'h0061 && c <= 16'h007A) begin
      return c - 16'h0020;
    end
    return c;
  endfunction

  task automatic reset_root_build();
    build_pos = 0;
    build_ovf = 1'b0;
  endtask

  task automatic reset_path_walk();
    walk_pos = 0;
    hit = 1'b0;
    for (int r = 0; r < ROOTS; r++) live[r] = 1'b1;
  endtask

  // Advance the bench state by one accepted item and queue an answer when it ends a root or path
  task automatic predict_answer(input logic [1:0] req, input logic [15:0] ch,
                                input logic last);
    answer_t     ans;
    int unsigned len;
    int unsigned p;
    logic [15:0] rc;
    ans.kind = ANS_ROOT;
    ans.status = ST_OK;
    ans.matched = 1'b0;
    case (req)
      REQ_CLEAR: begin
        root_cnt = 0;
        for (int r = 0; r < ROOTS; r++) root_len[r] = 0;
        reset_root_build();
        reset_path_walk();
      end
      REQ_ROOT: begin
        if (build_pos >= ROOT_CHARS) begin
          build_ovf = 1'b1;
        end else begin
          if (root_cnt < ROOTS) root_chars[root_cnt][build_pos] = ch;
          build_pos++;
        end
        if (last) begin
          if (build_ovf) begin
            ans.status = ST_TOO_LONG;
          end else if (root_cnt >= ROOTS) begin
            ans.status = ST_QUOTA;
          end else begin
            root_len[root_cnt] = build_pos;
            // a root finished mid-path joins from the next path on
            live[root_cnt] = (walk_pos == 0);
            root_cnt++;
          end
          reset_root_build();
          pending_answers.push_back(ans);
        end
      end
      REQ_PATH: begin
        p = walk_pos;
        for (int r = 0; r < root_cnt; r++) begin
          if (!live[r]) continue;
          len = root_len[r];
          if (p < len) begin
            rc = root_chars[r][p];
            if (upcase(rc) != upcase(ch)) begin
              live[r] = 1'b0;
            end else if (p == len - 1 && (rc == BACKSLASH || last)) begin
              hit = 1'b1;
            end
          end else if (p == len) begin
            if (ch == BACKSLASH) hit = 1'b1;
            live[r] = 1'b0;
          end
        end
        if (walk_pos <= ROOT_CHARS) walk_pos++;
        if (last) begin
          ans.kind = ANS_PATH;
          ans.matched = hit;
          pending_answers.push_back(ans);
          reset_path_walk();
        end
      end
      default: ;
    endcase
  endtask

  // Track every accepted input item
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      predict_answer(in_tuser, in_tdata, in_tlast);
    end
  end

  // Drive result ready: long hold-off first, else random stalls
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Compare each accepted result item with the oldest expectation
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result item kind %0d data 0x%02h", $time,
                 out_tuser, out_tdata);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        if (out_tuser !== want.kind) begin
          $display("%0t: answer_kind expected %0d, actual %0d", $time,
                   want.kind, out_tuser);
          errors++;
        end
        if (out_tdata[1:0] !== want.status) begin
          $display("%0t: add_status expected %0d, actual %0d", $time,
                   want.status, out_tdata[1:0]);
          errors++;
        end
        if (out_tdata[2] !== want.matched) begin
          $display("%0t: path_matched expected %0d, actual %0d", $time,
                   want.matched, out_tdata[2]);
          errors++;
        end
        if (out_tdata[7:3] !== 5'd0) begin
          $display("%0t: tdata padding expected 0, actual 0x%02h", $time,
                   out_tdata[7:3]);
          errors++;
        end
        if (want.kind == ANS_PATH) begin
          if (want.matched) paths_matched++;
          else paths_missed++;
        end else begin
          case (want.status)
            ST_OK:       roots_stored++;
            ST_TOO_LONG: roots_too_long++;
            default:     roots_over_quota++;
          endcase
        end
      end
    end
  end

  // Offer one item after random idle cycles and hold it until taken
  task automatic send_item(input logic [1:0] req, input logic [15:0] ch,
                           input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= ch;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (req != REQ_UNUSED) items_sent++;
  endtask

  // Send an ASCII string as one root or path, last on its final character
  task automatic send_text(input logic [1:0] req, input string s);
    for (int k = 0; k < s.len(); k++) begin
      send_item(req, {8'h00, s[k]}, k == s.len() - 1);
    end
  endtask

  // Let the last accepted item reach the predictor, then wait for all results
  task automatic wait_drained();
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // Weighted character mix around the folding and separator codes
  function automatic logic [15:0] pick_char();
    logic [15:0] edges [5] = '{16'h0040, 16'h005B, 16'h0060, 16'h007B, 16'h003A};
    case ($urandom_range(9))
      0, 1, 2, 3: return 16'(16'h0061 + $urandom_range(25));
      4, 5:       return 16'(16'h0041 + $urandom_range(25));
      6:          return BACKSLASH;
      7:          return edges[$urandom_range(4)];
      8:          return 16'(16'h0030 + $urandom_range(9));
      default:    return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] flip_case(input logic [15:0] c);
    if (upcase(c) >= 16'h0041 && upcase(c) <= 16'h005A && $urandom_range(1)) begin
      return c ^ 16'h0020;
    end
    return c;
  endfunction

  task automatic send_random_root(input bit short_only);
    int n;
    int sel;
    sel = $urandom_range(99);
    if (short_only || sel < 92) n = $urandom_range(8, 1);
    else if (sel < 96) n = $urandom_range(40, 9);
    else n = $urandom_range(ROOT_CHARS + 2, ROOT_CHARS - 6);
    for (int k = 0; k < n; k++) begin
      if (k == n - 1 && $urandom_range(4) == 0) send_item(REQ_ROOT, BACKSLASH, 1'b1);
      else send_item(REQ_ROOT, pick_char(), k == n - 1);
    end
  endtask

  // Mostly paths built on a stored root, with case changes and edits
  task automatic send_random_path();
    logic [15:0] chars [$];
    int r, n, cut, mid;
    if (root_cnt != 0 && $urandom_range(99) < 75) begin
      r = $urandom_range(root_cnt - 1);
      n = root_len[r];
      for (int k = 0; k < n; k++) chars.push_back(flip_case(root_chars[r][k]));
      case ($urandom_range(4))
        0: ;
        1: begin
          chars.push_back(BACKSLASH);
          repeat ($urandom_range(4)) chars.push_back(pick_char());
        end
        2: begin
          chars.push_back(16'(16'h0061 + $urandom_range(25)));
          repeat ($urandom_range(4)) chars.push_back(pick_char());
        end
        3: chars[$urandom_range(n - 1)] = pick_char();
        default: begin
          cut = $urandom_range(n);
          while (chars.size() > cut && chars.size() > 1) void'(chars.pop_back());
        end
      endcase
    end else begin
      repeat ($urandom_range(10, 1)) chars.push_back(pick_char());
    end
    if ($urandom_range(29) == 0) begin
      repeat ($urandom_range(ROOT_CHARS + 20, ROOT_CHARS - 4)) chars.push_back(pick_char());
    end
    // break some sequences: a root in the middle, or a clear instead of the end
    mid = ($urandom_range(14) == 0) ? $urandom_range(chars.size() - 1) : -1;
    for (int k = 0; k < chars.size(); k++) begin
      if (k == mid) send_random_root(1'b1);
      if (k == chars.size() - 1 && $urandom_range(39) == 0) begin
        send_item(REQ_CLEAR, 16'($urandom), 1'($urandom_range(1)));
      end else begin
        send_item(REQ_PATH, chars[k], k == chars.size() - 1);
      end
    end
  endtask

  // ---- directed tests ----

  task automatic test_empty_table();
    send_item(REQ_CLEAR, 16'hFFFF, 1'b1);
    send_text(REQ_PATH, "a\\");
    send_item(REQ_UNUSED, 16'hFFFF, 1'b1);
    send_item(REQ_UNUSED, 16'h0000, 1'b0);
    send_text(REQ_PATH, "q");
  endtask

  task automatic test_path_boundaries();
    send_item(REQ_CLEAR, 16'h0000, 1'b0);
    send_text(REQ_ROOT, "ab");
    send_text(REQ_ROOT, "C:\\");
    send_text(REQ_PATH, "AB");
    send_text(REQ_PATH, "ab\\x");
    send_text(REQ_PATH, "abc");
    send_text(REQ_PATH, "a");
    send_text(REQ_PATH, "c:\\w");
    send_text(REQ_PATH, "c:");
  endtask

  task automatic test_case_folding();
    send_item(REQ_CLEAR, 16'h1234, 1'b0);
    send_text(REQ_ROOT, "az");
    send_text(REQ_ROOT, "`{");
    send_text(REQ_PATH, "AZ");
    send_text(REQ_PATH, "@[");
    send_text(REQ_PATH, "`{");
  endtask

  task automatic test_extreme_codes();
    send_item(REQ_CLEAR, 16'h0000, 1'b0);
    send_item(REQ_ROOT, 16'hFFFF, 1'b0);
    send_item(REQ_ROOT, 16'h0000, 1'b1);
    send_item(REQ_PATH, 16'hFFFF, 1'b0);
    send_item(REQ_PATH, 16'h0000, 1'b1);
    send_item(REQ_PATH, 16'hFFFF, 1'b0);
    send_item(REQ_PATH, 16'h0001, 1'b1);
  endtask

  task automatic test_root_during_path();
    send_item(REQ_CLEAR, 16'h0000, 1'b0);
    send_item(REQ_PATH, 16'h0078, 1'b0);
    send_text(REQ_ROOT, "x");
    send_item(REQ_PATH, BACKSLASH, 1'b1);
    send_text(REQ_PATH, "X");
  endtask

  task automatic test_clear_mid_stream();
    send_text(REQ_ROOT, "ab\\");
    send_item(REQ_ROOT, 16'h0061, 1'b0);
    send_item(REQ_CLEAR, 16'hFFFF, 1'b1);
    send_text(REQ_ROOT, "q");
    send_item(REQ_PATH, 16'h0071, 1'b0);
    send_item(REQ_CLEAR, 16'h0000, 1'b0);
    send_text(REQ_PATH, "q");
    send_text(REQ_ROOT, "q");
    send_text(REQ_PATH, "q");
  endtask

  // Full-length root, quota, too long
  task automatic test_root_limits();
    send_item(REQ_CLEAR, 16'h0000, 1'b0);
    for (int k = 0; k < ROOT_CHARS; k++) begin
      send_item(REQ_ROOT, 16'(16'h0041 + k % 26), k == ROOT_CHARS - 1);
    end
    send_text(REQ_PATH, "abc");
    for (int k = 1; k < ROOTS; k++) send_item(REQ_ROOT, 16'(16'h0030 + k), 1'b1);
    send_text(REQ_ROOT, "z");
    for (int k = 0; k <= ROOT_CHARS; k++) begin
      send_item(REQ_ROOT, 16'(16'h0061 + k % 26), k == ROOT_CHARS);
    end
    send_text(REQ_PATH, "3");
  endtask

  // ---- random tests ----

  task automatic test_random_traffic(input int tx_pct, input int rx_pct,
                                     input int n_items);
    int stop_at;
    int sel;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      sel = $urandom_range(99);
      if (sel < 4) send_item(REQ_CLEAR, 16'($urandom), 1'($urandom_range(1)));
      else if (sel < 8) send_item(REQ_UNUSED, 16'($urandom), 1'($urandom_range(1)));
      else if (sel < 48) send_random_root(1'b0);
      else send_random_path();
    end
    in_tvalid <= 1'b0;
    wait_drained();
  endtask

  // Hold the receiver off while items keep coming, so the input stalls
  task automatic test_backpressure();
    stall_left = 400;
    test_random_traffic(0, 0, 30);
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= 16'h0000;
    in_tuser   <= REQ_CLEAR;
    in_tlast   <= 1'b0;
    out_tready <= 1'b0;
    root_cnt = 0;
    for (int r = 0; r < ROOTS; r++) root_len[r] = 0;
    reset_root_build();
    reset_path_walk();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 8;
    rx_idle_pct = 59;
    test_empty_table();
    test_path_boundaries();
    test_case_folding();
    test_extreme_codes();
    test_root_during_path();
    test_clear_mid_stream();
    test_root_limits();
    in_tvalid <= 1'b0;
    wait_drained();

    test_random_traffic(8, 59, 50);
    test_random_traffic(59, 8, 50);
    test_random_traffic(0, 0, 40);
    test_backpressure();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d items: roots stored %0d, too long %0d, over quota %0d",
             items_sent, roots_stored, roots_too_long, roots_over_quota);
    $display("Path answers: %0d matched, %0d not matched", paths_matched, paths_missed);
    if (pending_answers.size() != 0) begin
      $display("%0t: %0d expected result items never arrived", $time,
               pending_answers.size());
    end
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5_000_000;
    $display("%0t: run timed out", $time);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/prm_pkg.sv
sv/prm_text_ram.sv
sv/path_root_prefix_matcher.sv
dv/tb_path_root_prefix_matcher.sv
